// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the clustering unit RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TSCU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define TSCU_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/tscu_pkg.sv =====
// Package of the threshold subcluster clustering unit.
// Holds sizes, codes and the divider request type; depends on nothing.
`default_nettype none

package tscu_pkg;

  localparam int MAX_SUB    = 16;
  localparam int DIMS       = 4;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 4;
  localparam int DIM_W      = 2;
  localparam int LIVE_W     = 5;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int DIST_W     = 34;
  localparam int THR_W      = 16;
  localparam int LIM_W      = 4;
  localparam int NDIM_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int ADDR_W     = IDX_W + DIM_W;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LABEL  = 2'd2
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_USED    = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST    = 16'd256;
  localparam logic [LIM_W-1:0]  BRANCH_LIMIT_RST = 4'd15;
  localparam logic [NDIM_W-1:0] DIMS_USED_RST    = 3'd4;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== hdl/threshold_subcluster_clustering_unit.sv =====
// Threshold subcluster clustering unit, a flat table of up to 16 subclusters.
// Uses tscu_pkg, tscu_div and assert_macros.svh.
//
// Input channel (in_valid_i/in_ready_o) carries an action and four coordinates;
// output channel (out_valid_o/out_ready_i) returns one result per transaction.
// Configuration writes arrive on cfg_valid_i/cfg_data_i, always ready.
// One item is worked on at a time; in_ready_o is high only while the sequencer
// is idle. A clear empties the table. A label or an insert into a non-empty
// table first scans every entry through one shared squared-distance unit, one
// coordinate at a time (read, multiply, accumulate). An absorb then updates the
// count and, per used coordinate, the sum and the centroid through the one-bit-per-cycle
// divider; appending writes all four coordinates of a new entry. Each merge scans
// every pair the same way, then divides once per used coordinate and shifts each
// entry above the merged one down, one coordinate per read-write pass.
// Reset empties the table and loads the default registers. A finished result
// waits in the output register; a stalled receiver holds the next item at its
// last step until the register frees.
`default_nettype none
`include "assert_macros.svh"

module threshold_subcluster_clustering_unit (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [1:0]                                  action_i,
  input  logic signed [tscu_pkg::COORD_BITS-1:0]      coord_0_i,
  input  logic signed [tscu_pkg::COORD_BITS-1:0]      coord_1_i,
  input  logic signed [tscu_pkg::COORD_BITS-1:0]      coord_2_i,
  input  logic signed [tscu_pkg::COORD_BITS-1:0]      coord_3_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [tscu_pkg::IDX_W-1:0]                  label_o,
  output logic [tscu_pkg::LIVE_W-1:0]                 live_count_o,
  output logic                                        created_o,
  output logic                                        merged_o,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [tscu_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [tscu_pkg::THR_W-1:0]                  cfg_data_i
);

  localparam int IW = tscu_pkg::IDX_W;
  localparam int DW = tscu_pkg::DIM_W;
  localparam int LW = tscu_pkg::LIVE_W;
  localparam int CW = tscu_pkg::COORD_BITS;
  localparam int SW = tscu_pkg::SUM_W;
  localparam int NW = tscu_pkg::CNT_W;
  localparam int XW = tscu_pkg::DIST_W;
  localparam int AW = tscu_pkg::ADDR_W;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_DRA  = 18'h00002,
    S_DRB  = 18'h00004,
    S_DMUL = 18'h00008,
    S_DACC = 18'h00010,
    S_DEC  = 18'h00020,
    S_CRD  = 18'h00040,
    S_CRD2 = 18'h00080,
    S_CWR  = 18'h00100,
    S_SRD  = 18'h00200,
    S_SRD2 = 18'h00400,
    S_SWR  = 18'h00800,
    S_DIV  = 18'h01000,
    S_APP  = 18'h02000,
    S_LIM  = 18'h04000,
    S_SHR  = 18'h08000,
    S_SHW  = 18'h10000,
    S_FIN  = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // Table memories.
  logic [NW-1:0]        cnt_mem [tscu_pkg::MAX_SUB];
  logic signed [SW-1:0] sum_mem [tscu_pkg::MAX_SUB * tscu_pkg::DIMS];
  logic signed [CW-1:0] cen_mem [tscu_pkg::MAX_SUB * tscu_pkg::DIMS];

  logic [IW-1:0]        cnt_raddr, cnt_waddr;
  logic [AW-1:0]        sum_raddr, sum_waddr, cen_raddr, cen_waddr;
  logic                 cnt_we, sum_we, cen_we;
  logic [NW-1:0]        cnt_wdata, cnt_rd_q;
  logic signed [SW-1:0] sum_wdata, sum_rd_q;
  logic signed [CW-1:0] cen_wdata, cen_rd_q;

  // Configuration.
  logic [tscu_pkg::THR_W-1:0]  thr_q;
  logic [tscu_pkg::LIM_W-1:0]  blim_q;
  logic [tscu_pkg::NDIM_W-1:0] dims_q;
  logic [2*tscu_pkg::THR_W-1:0] thr_sq_q;

  // Working registers.
  logic signed [CW-1:0] pt_q [tscu_pkg::DIMS];
  logic signed [CW-1:0] pt_d [tscu_pkg::DIMS];
  logic [1:0]           act_q, act_d;
  logic                 pair_q, pair_d, merge_q, merge_d;
  logic                 created_q, created_d, merged_q, merged_d;
  logic [IW-1:0]        a_q, a_d, b_q, b_d, k_q, k_d, bi_q, bi_d, bj_q, bj_d;
  logic [DW-1:0]        d_q, d_d;
  logic [XW-1:0]        acc_q, acc_d, best_q, best_d;
  logic                 found_q, found_d;
  logic signed [CW-1:0] opa_q, opa_d;
  logic [2*CW-1:0]      sq_q, sq_d;
  logic [NW-1:0]        cnt_a_q, cnt_a_d, cnt_new_q, cnt_new_d;
  logic signed [SW-1:0] sum_a_q, sum_a_d;
  logic [LW-1:0]        live_q, live_d;

  logic                 out_valid_q, out_valid_d;
  logic [IW-1:0]        label_q, label_d;
  logic [LW-1:0]        live_out_q, live_out_d;
  logic                 created_out_q, created_out_d, merged_out_q, merged_out_d;

  // Derived values.
  logic [DW-1:0]        nd_last;
  logic [IW-1:0]        eff_lim;
  logic [IW-1:0]        k_nx;
  logic                 in_acc;
  logic signed [CW:0]   diff;
  logic [CW-1:0]        diff_mag;
  logic [XW-1:0]        acc_new;
  logic                 better;
  logic [NW:0]          cnt_sum;
  logic signed [SW-1:0] add_x, add_y, sum_sat;
  logic signed [SW:0]   add_full;

  tscu_pkg::div_req_t   div_req;
  logic                 div_done;
  logic signed [CW-1:0] div_quot;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    if (dims_q == '0) begin
      nd_last = '0;
    end else if (dims_q >= tscu_pkg::NDIM_W'(tscu_pkg::DIMS)) begin
      nd_last = DW'(tscu_pkg::DIMS - 1);
    end else begin
      nd_last = DW'(dims_q - 1'b1);
    end
  end

  assign eff_lim  = (blim_q == '0) ? IW'(1) : blim_q;
  assign k_nx     = k_q + 1'b1;
  assign diff     = {opa_q[CW-1], opa_q} - {cen_rd_q[CW-1], cen_rd_q};
  assign diff_mag = diff[CW] ? CW'(-diff) : diff[CW-1:0];
  assign acc_new  = ((d_q == '0) ? XW'(0) : acc_q) + XW'(sq_q);
  assign better   = !found_q || (acc_new < best_q);
  assign cnt_sum  = {1'b0, cnt_a_q} + {1'b0, cnt_rd_q};
  assign add_x    = merge_q ? sum_a_q : sum_rd_q;
  assign add_y    = merge_q ? sum_rd_q : SW'(pt_q[d_q]);
  assign add_full = {add_x[SW-1], add_x} + {add_y[SW-1], add_y};

  // Saturate the linear sum at its signed range.
  always_comb begin
    if (add_full[SW] != add_full[SW-1]) begin
      sum_sat = add_full[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = add_full[SW-1:0];
    end
  end

  always_comb begin
    state_d        = state_q;
    pt_d           = pt_q;
    act_d          = act_q;
    pair_d         = pair_q;
    merge_d        = merge_q;
    created_d      = created_q;
    merged_d       = merged_q;
    a_d            = a_q;
    b_d            = b_q;
    k_d            = k_q;
    bi_d           = bi_q;
    bj_d           = bj_q;
    d_d            = d_q;
    acc_d          = acc_q;
    best_d         = best_q;
    found_d        = found_q;
    opa_d          = opa_q;
    sq_d           = sq_q;
    cnt_a_d        = cnt_a_q;
    cnt_new_d      = cnt_new_q;
    sum_a_d        = sum_a_q;
    live_d         = live_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    label_d        = label_q;
    live_out_d     = live_out_q;
    created_out_d  = created_out_q;
    merged_out_d   = merged_out_q;

    cnt_raddr = bi_q;
    sum_raddr = {bi_q, d_q};
    cen_raddr = {b_q, d_q};
    cnt_we    = 1'b0;
    cnt_waddr = bi_q;
    cnt_wdata = cnt_rd_q;
    sum_we    = 1'b0;
    sum_waddr = {bi_q, d_q};
    sum_wdata = sum_sat;
    cen_we    = 1'b0;
    cen_waddr = {bi_q, d_q};
    cen_wdata = div_quot;

    div_req.start    = 1'b0;
    div_req.dividend = sum_sat;
    div_req.divisor  = cnt_new_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pt_d[0]   = coord_0_i;
          pt_d[1]   = coord_1_i;
          pt_d[2]   = coord_2_i;
          pt_d[3]   = coord_3_i;
          act_d     = action_i;
          created_d = 1'b0;
          merged_d  = 1'b0;
          pair_d    = 1'b0;
          merge_d   = 1'b0;
          b_d       = '0;
          d_d       = '0;
          found_d   = 1'b0;
          state_d   = S_FIN;
          case (action_i)
            tscu_pkg::ACT_CLEAR: begin
              live_d = '0;
            end
            tscu_pkg::ACT_INSERT: begin
              state_d = (live_q == '0) ? S_APP : S_DRB;
            end
            tscu_pkg::ACT_LABEL: begin
              if (live_q != '0) begin
                state_d = S_DRB;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_DRA: begin
        cen_raddr = {a_q, d_q};
        state_d   = S_DRB;
      end

      S_DRB: begin
        cen_raddr = {b_q, d_q};
        opa_d     = pair_q ? cen_rd_q : pt_q[d_q];
        state_d   = S_DMUL;
      end

      S_DMUL: begin
        sq_d    = diff_mag * diff_mag;
        state_d = S_DACC;
      end

      S_DACC: begin
        acc_d = acc_new;
        if (d_q == nd_last) begin
          d_d = '0;
          if (better) begin
            best_d  = acc_new;
            bi_d    = pair_q ? a_q : b_q;
            bj_d    = b_q;
            found_d = 1'b1;
          end
          if (pair_q) begin
            if ({1'b0, b_q} + 1'b1 < live_q) begin
              b_d     = b_q + 1'b1;
              state_d = S_DRA;
            end else if ({1'b0, a_q} + LW'(2) < live_q) begin
              a_d     = a_q + 1'b1;
              b_d     = a_q + IW'(2);
              state_d = S_DRA;
            end else begin
              state_d = S_CRD;
            end
          end else begin
            if ({1'b0, b_q} + 1'b1 < live_q) begin
              b_d     = b_q + 1'b1;
              state_d = S_DRB;
            end else if (act_q == tscu_pkg::ACT_LABEL) begin
              state_d = S_FIN;
            end else begin
              state_d = S_DEC;
            end
          end
        end else begin
          d_d     = d_q + 1'b1;
          state_d = pair_q ? S_DRA : S_DRB;
        end
      end

      S_DEC: begin
        d_d = '0;
        if (best_q < XW'(thr_sq_q)) begin
          state_d = S_CRD;
        end else begin
          state_d = S_APP;
        end
      end

      S_CRD: begin
        cnt_raddr = bi_q;
        state_d   = merge_q ? S_CRD2 : S_CWR;
      end

      S_CRD2: begin
        cnt_raddr = bj_q;
        cnt_a_d   = cnt_rd_q;
        state_d   = S_CWR;
      end

      S_CWR: begin
        cnt_we = 1'b1;
        if (merge_q) begin
          cnt_wdata = cnt_sum[NW] ? '1 : cnt_sum[NW-1:0];
        end else begin
          cnt_wdata = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;
        end
        cnt_new_d = cnt_wdata;
        d_d       = '0;
        state_d   = S_SRD;
      end

      S_SRD: begin
        sum_raddr = {bi_q, d_q};
        state_d   = merge_q ? S_SRD2 : S_SWR;
      end

      S_SRD2: begin
        sum_raddr = {bj_q, d_q};
        sum_a_d   = sum_rd_q;
        state_d   = S_SWR;
      end

      S_SWR: begin
        sum_we        = 1'b1;
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          cen_we = 1'b1;
          if (d_q == nd_last) begin
            d_d = '0;
            if (merge_q) begin
              k_d     = bj_q;
              state_d = S_SHR;
            end else begin
              state_d = S_LIM;
            end
          end else begin
            d_d     = d_q + 1'b1;
            state_d = S_SRD;
          end
        end
      end

      S_APP: begin
        cnt_we    = 1'b1;
        cnt_waddr = live_q[IW-1:0];
        cnt_wdata = NW'(1);
        sum_we    = 1'b1;
        sum_waddr = {live_q[IW-1:0], d_q};
        sum_wdata = SW'(pt_q[d_q]);
        cen_we    = 1'b1;
        cen_waddr = {live_q[IW-1:0], d_q};
        cen_wdata = pt_q[d_q];
        if (d_q == DW'(tscu_pkg::DIMS - 1)) begin
          d_d       = '0;
          live_d    = live_q + 1'b1;
          created_d = 1'b1;
          state_d   = S_LIM;
        end else begin
          d_d = d_q + 1'b1;
        end
      end

      S_LIM: begin
        if (live_q > {1'b0, eff_lim}) begin
          merged_d = 1'b1;
          pair_d   = 1'b1;
          merge_d  = 1'b1;
          a_d      = '0;
          b_d      = IW'(1);
          d_d      = '0;
          found_d  = 1'b0;
          state_d  = S_DRA;
        end else begin
          state_d = S_FIN;
        end
      end

      // Entries above the merged one move down by one, a coordinate per pass.
      S_SHR: begin
        cnt_raddr = k_nx;
        sum_raddr = {k_nx, d_q};
        cen_raddr = {k_nx, d_q};
        if ({1'b0, k_q} + 1'b1 < live_q) begin
          state_d = S_SHW;
        end else begin
          live_d  = live_q - 1'b1;
          state_d = S_LIM;
        end
      end

      S_SHW: begin
        cnt_we    = 1'b1;
        cnt_waddr = k_q;
        cnt_wdata = cnt_rd_q;
        sum_we    = 1'b1;
        sum_waddr = {k_q, d_q};
        sum_wdata = sum_rd_q;
        cen_we    = 1'b1;
        cen_waddr = {k_q, d_q};
        cen_wdata = cen_rd_q;
        if (d_q == DW'(tscu_pkg::DIMS - 1)) begin
          d_d = '0;
          k_d = k_nx;
        end else begin
          d_d = d_q + 1'b1;
        end
        state_d = S_SHR;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          label_d       = ((act_q == tscu_pkg::ACT_LABEL) && (live_q != '0)) ? bi_q : '0;
          live_out_d    = live_q;
          created_out_d = created_q;
          merged_out_d  = merged_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= tscu_pkg::THRESHOLD_RST;
      blim_q      <= tscu_pkg::BRANCH_LIMIT_RST;
      dims_q      <= tscu_pkg::DIMS_USED_RST;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tscu_pkg::CFG_THRESHOLD:    thr_q  <= cfg_data_i;
          tscu_pkg::CFG_BRANCH_LIMIT: blim_q <= cfg_data_i[tscu_pkg::LIM_W-1:0];
          tscu_pkg::CFG_DIMS_USED:    dims_q <= cfg_data_i[tscu_pkg::NDIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q      <= thr_q * thr_q;
    pt_q          <= pt_d;
    act_q         <= act_d;
    pair_q        <= pair_d;
    merge_q       <= merge_d;
    created_q     <= created_d;
    merged_q      <= merged_d;
    a_q           <= a_d;
    b_q           <= b_d;
    k_q           <= k_d;
    bi_q          <= bi_d;
    bj_q          <= bj_d;
    d_q           <= d_d;
    acc_q         <= acc_d;
    best_q        <= best_d;
    found_q       <= found_d;
    opa_q         <= opa_d;
    sq_q          <= sq_d;
    cnt_a_q       <= cnt_a_d;
    cnt_new_q     <= cnt_new_d;
    sum_a_q       <= sum_a_d;
    label_q       <= label_d;
    live_out_q    <= live_out_d;
    created_out_q <= created_out_d;
    merged_out_q  <= merged_out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) begin
      cen_mem[cen_waddr] <= cen_wdata;
    end
    cen_rd_q <= cen_mem[cen_raddr];
  end

  tscu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_valid_o  = out_valid_q;
  assign label_o      = label_q;
  assign live_count_o = live_out_q;
  assign created_o    = created_out_q;
  assign merged_o     = merged_out_q;

  `TSCU_ASSERT(a_live_max, live_q <= LW'(tscu_pkg::MAX_SUB), "table holds too many entries")
  `TSCU_ASSERT(a_lim_kept, (state_q == S_FIN) && (created_q || merged_q) |-> live_q <= {1'b0, eff_lim}, "insert finished above branch limit")
  `TSCU_ASSERT(a_pair_order, (state_q == S_DACC) && pair_q |-> (a_q < b_q) && ({1'b0, b_q} < live_q), "pair scan out of order")

endmodule

`default_nettype wire

// ===== hdl/tscu_div.sv =====
// Restoring divider, one quotient bit per cycle, for centroid = sum / count.
// Truncates toward zero and clamps to the coordinate range; uses tscu_pkg.
`default_nettype none

module tscu_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  tscu_pkg::div_req_t                        req_i,
  output logic                                      done_o,
  output logic signed [tscu_pkg::COORD_BITS-1:0]    quot_o
);

  localparam int STEP_W = $clog2(tscu_pkg::SUM_W);

  logic                          busy_q, done_q, neg_q;
  logic [STEP_W-1:0]             step_q;
  logic [tscu_pkg::CNT_W:0]      rem_q;
  logic [tscu_pkg::SUM_W-1:0]    quo_q;
  logic [tscu_pkg::CNT_W-1:0]    den_q;

  logic [tscu_pkg::CNT_W:0]      rem_sh;
  logic                          ge;
  logic [tscu_pkg::SUM_W-1:0]    mag;

  assign rem_sh = {rem_q[tscu_pkg::CNT_W-1:0], quo_q[tscu_pkg::SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign mag    = req_i.dividend[tscu_pkg::SUM_W-1] ? tscu_pkg::SUM_W'(-req_i.dividend)
                                                    : tscu_pkg::SUM_W'(req_i.dividend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(tscu_pkg::SUM_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= mag;
      den_q <= req_i.divisor;
      neg_q <= req_i.dividend[tscu_pkg::SUM_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[tscu_pkg::SUM_W-2:0], ge};
    end
  end

  // The magnitude of the most negative coordinate is one above the largest positive.
  always_comb begin
    if (neg_q) begin
      if (quo_q > tscu_pkg::SUM_W'(2 ** (tscu_pkg::COORD_BITS - 1))) begin
        quot_o = {1'b1, {(tscu_pkg::COORD_BITS-1){1'b0}}};
      end else begin
        quot_o = -$signed(quo_q[tscu_pkg::COORD_BITS-1:0]);
      end
    end else begin
      if (quo_q > tscu_pkg::SUM_W'(2 ** (tscu_pkg::COORD_BITS - 1) - 1)) begin
        quot_o = {1'b0, {(tscu_pkg::COORD_BITS-1){1'b1}}};
      end else begin
        quot_o = $signed(quo_q[tscu_pkg::COORD_BITS-1:0]);
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for threshold_subcluster_clustering_unit.
// Depends on tscu_pkg; an in-bench table model predicts every result from accepted
// transactions and a checker process compares them in order.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [tscu_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 100000;
  localparam int MAX_GAP = 18;

  typedef logic signed [tscu_pkg::COORD_BITS-1:0] coord_t;
  typedef longint vec_t [tscu_pkg::DIMS];
  typedef struct packed {
    logic [tscu_pkg::IDX_W-1:0]  label;
    logic [tscu_pkg::LIVE_W-1:0] live;
    logic                        created;
    logic                        merged;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = 2'd0;
  coord_t crd0 = '0, crd1 = '0, crd2 = '0, crd3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [tscu_pkg::IDX_W-1:0] label;
  logic [tscu_pkg::LIVE_W-1:0] live_count;
  logic created, merged;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tscu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tscu_pkg::THR_W-1:0] cfg_data = '0;

  threshold_subcluster_clustering_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .action_i(action),
    .coord_0_i(crd0), .coord_1_i(crd1), .coord_2_i(crd2), .coord_3_i(crd3),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .label_o(label), .live_count_o(live_count), .created_o(created), .merged_o(merged),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table model state and its copy of the registers.
  int unsigned thr_reg = tscu_pkg::THRESHOLD_RST;
  int unsigned limit_reg = tscu_pkg::BRANCH_LIMIT_RST;
  int unsigned dims_reg = tscu_pkg::DIMS_USED_RST;
  int unsigned sub_count [tscu_pkg::MAX_SUB];
  vec_t sub_sum [tscu_pkg::MAX_SUB];
  vec_t sub_cen [tscu_pkg::MAX_SUB];
  int unsigned live_subs = 0;

  result_t expected_q [$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  function automatic longint unsigned sq_dist(vec_t a, vec_t b, int nd);
    longint unsigned acc, m, sq;
    longint diff;
    acc = 0;
    for (int d = 0; d < nd; d++) begin
      diff = a[d] - b[d];
      m = (diff < 0) ? -diff : diff;
      sq = (m > 64'hFFFF_FFFF) ? '1 : m * m;
      acc = (acc > ~sq) ? '1 : acc + sq;
    end
    return acc;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    return s;
  endfunction

  function automatic void refresh_centroid(int k, int nd);
    longint c;
    if (sub_count[k] == 0) return;
    for (int d = 0; d < nd; d++) begin
      c = sub_sum[k][d] / longint'(sub_count[k]);
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      sub_cen[k][d] = c;
    end
  endfunction

  function automatic int nearest_sub(vec_t pt, int nd, output longint unsigned best);
    int idx;
    longint unsigned dsq;
    idx = 0;
    best = 0;
    for (int j = 0; j < live_subs; j++) begin
      dsq = sq_dist(pt, sub_cen[j], nd);
      if (j == 0 || dsq < best) begin
        best = dsq;
        idx = j;
      end
    end
    return idx;
  endfunction

  // Merges the closest pair into the lower index and shifts later entries down.
  function automatic void merge_closest(int nd);
    int mi, mj;
    longint unsigned best, dsq;
    longint total;
    mi = 0;
    mj = 1;
    best = 0;
    for (int a = 0; a < live_subs; a++)
      for (int b = a + 1; b < live_subs; b++) begin
        dsq = sq_dist(sub_cen[a], sub_cen[b], nd);
        if ((a == 0 && b == 1) || dsq < best) begin
          best = dsq;
          mi = a;
          mj = b;
        end
      end
    total = longint'(sub_count[mi]) + longint'(sub_count[mj]);
    sub_count[mi] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(total);
    for (int d = 0; d < nd; d++) sub_sum[mi][d] = sat_sum(sub_sum[mi][d], sub_sum[mj][d]);
    refresh_centroid(mi, nd);
    for (int k = mj; k + 1 < live_subs; k++) begin
      sub_count[k] = sub_count[k + 1];
      sub_sum[k] = sub_sum[k + 1];
      sub_cen[k] = sub_cen[k + 1];
    end
    live_subs--;
  endfunction

  function automatic result_t predict_result(logic [1:0] act, coord_t x0, coord_t x1,
                                             coord_t x2, coord_t x3);
    result_t r;
    vec_t pt;
    int nd, lim, idx, k;
    longint unsigned best, thr;
    r = '0;
    nd = (dims_reg < 1) ? 1 : (dims_reg > tscu_pkg::DIMS) ? tscu_pkg::DIMS : dims_reg;
    lim = (limit_reg < 1) ? 1 :
          (limit_reg > tscu_pkg::MAX_SUB - 1) ? tscu_pkg::MAX_SUB - 1 : limit_reg;
    pt[0] = x0;
    pt[1] = x1;
    pt[2] = x2;
    pt[3] = x3;
    case (act)
      tscu_pkg::ACT_CLEAR: live_subs = 0;
      tscu_pkg::ACT_INSERT: begin
        idx = nearest_sub(pt, nd, best);
        thr = thr_reg;
        if (live_subs > 0 && best < thr * thr) begin
          if (sub_count[idx] != 32'hFFFF_FFFF) sub_count[idx]++;
          for (int d = 0; d < nd; d++) sub_sum[idx][d] = sat_sum(sub_sum[idx][d], pt[d]);
          refresh_centroid(idx, nd);
        end else begin
          if (live_subs >= tscu_pkg::MAX_SUB) begin
            merge_closest(nd);
            r.merged = 1'b1;
          end
          k = live_subs;
          sub_count[k] = 1;
          sub_sum[k] = pt;
          sub_cen[k] = pt;
          live_subs++;
          r.created = 1'b1;
        end
        while (live_subs > lim) begin
          merge_closest(nd);
          r.merged = 1'b1;
        end
      end
      tscu_pkg::ACT_LABEL: begin
        if (live_subs > 0) r.label = tscu_pkg::IDX_W'(nearest_sub(pt, nd, best));
      end
      default: ;
    endcase
    r.live = tscu_pkg::LIVE_W'(live_subs);
    return r;
  endfunction

  // Sends one transaction; valid stays high when the next one follows without a gap.
  task automatic send_item(logic [1:0] act, coord_t x0, coord_t x1, coord_t x2, coord_t x3);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    crd0 <= x0;
    crd1 <= x1;
    crd2 <= x2;
    crd3 <= x3;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_result(act, x0, x1, x2, x3));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [tscu_pkg::CFG_IDX_W-1:0] idx,
                           logic [tscu_pkg::THR_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tscu_pkg::CFG_THRESHOLD:    thr_reg = data;
      tscu_pkg::CFG_BRANCH_LIMIT: limit_reg = data[tscu_pkg::LIM_W-1:0];
      tscu_pkg::CFG_DIMS_USED:    dims_reg = data[tscu_pkg::NDIM_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int thr, int lim, int nd);
    write_cfg(tscu_pkg::CFG_THRESHOLD, tscu_pkg::THR_W'(thr), 1'b0);
    write_cfg(tscu_pkg::CFG_BRANCH_LIMIT, tscu_pkg::THR_W'(lim), 1'b0);
    write_cfg(tscu_pkg::CFG_DIMS_USED, tscu_pkg::THR_W'(nd), 1'b1);
  endtask

  task automatic test_directed();
    send_item(tscu_pkg::ACT_LABEL, 16'sh1234, 0, 0, 0);
    send_item(tscu_pkg::ACT_INSERT, 0, 0, 0, 0);
    send_item(tscu_pkg::ACT_CLEAR, 0, 0, 0, 0);
    send_item(tscu_pkg::ACT_INSERT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(tscu_pkg::ACT_INSERT, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    // Exactly the threshold away opens a new entry; one unit closer is absorbed.
    send_item(tscu_pkg::ACT_INSERT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7EFF);
    send_item(tscu_pkg::ACT_INSERT, 16'sh7FFF, 16'sh7FFF, 16'sh7F00, 16'sh7FFF);
    send_item(tscu_pkg::ACT_LABEL, 0, 0, 0, 0);
    send_item(tscu_pkg::ACT_LABEL, -16'sh8000, 16'sh7FFF, 0, -1);
    send_item(ACT_UNUSED, 16'sh7FFF, -1, 0, -16'sh8000);
    send_item(tscu_pkg::ACT_INSERT, 100, -100, 200, -200);
    send_item(tscu_pkg::ACT_INSERT, 101, -99, 199, -201);
    send_item(tscu_pkg::ACT_LABEL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    drain();
    // Out-of-range register values: limit 0 acts as 1, dims 0 acts as 1.
    write_cfg(tscu_pkg::CFG_THRESHOLD, 16'hFFFF, 1'b0);
    write_cfg(tscu_pkg::CFG_BRANCH_LIMIT, 16'h0000, 1'b0);
    write_cfg(tscu_pkg::CFG_DIMS_USED, 16'h0000, 1'b0);
    write_cfg(CFG_UNUSED, 16'hFFFF, 1'b1);
    send_item(tscu_pkg::ACT_INSERT, 1000, 2000, 3000, 4000);
    send_item(tscu_pkg::ACT_INSERT, -30000, 5, 6, 7);
    send_item(tscu_pkg::ACT_LABEL, 0, 0, 0, 0);
    drain();
    set_regs(0, 3, 7);
    send_item(tscu_pkg::ACT_INSERT, 5, 5, 5, 5);
    send_item(tscu_pkg::ACT_INSERT, 5, 5, 5, 5);
    send_item(tscu_pkg::ACT_INSERT, 9000, -9000, 5, 5);
    send_item(tscu_pkg::ACT_INSERT, -9000, 9000, 5, 5);
    send_item(tscu_pkg::ACT_LABEL, -8000, 8000, 0, 0);
    send_item(tscu_pkg::ACT_CLEAR, -1, -1, -1, -1);
    send_item(tscu_pkg::ACT_LABEL, 3, 3, 3, 3);
    drain();
  endtask

  // A lowered branch limit makes the next insert merge repeatedly.
  task automatic test_lowered_limit();
    set_regs(0, 15, 4);
    send_item(tscu_pkg::ACT_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      send_item(tscu_pkg::ACT_INSERT, coord_t'(i * 3000 - 15000), coord_t'(i * i * 200),
                coord_t'(-i * 1111), coord_t'(i * 7));
    drain();
    set_regs(300, 2, 4);
    send_item(tscu_pkg::ACT_INSERT, 0, 0, 0, 0);
    send_item(tscu_pkg::ACT_LABEL, 20000, 0, 0, 0);
    drain();
  endtask

  function automatic coord_t pick_coord(int ctr, int spread);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return coord_t'(ctr + int'($urandom_range(0, 2 * spread)) - spread);
    if (r < 9) return coord_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic test_random_phase(int n_items);
    int centers [6][tscu_pkg::DIMS];
    int spread, c, r, lim_pick;
    logic [1:0] act;
    case ($urandom_range(0, 5))
      0: r = 0;
      1: r = 16'hFFFF;
      2: r = $urandom_range(0, 16'hFFFF);
      default: r = $urandom_range(50, 3000);
    endcase
    lim_pick = $urandom_range(0, 9);
    if (lim_pick == 0) lim_pick = 0;
    else if (lim_pick == 1) lim_pick = 15;
    else lim_pick = $urandom_range(1, 6);
    set_regs(r, lim_pick, $urandom_range(0, 7));
    spread = $urandom_range(16, 1500);
    foreach (centers[i, d]) centers[i][d] = int'($urandom_range(0, 40000)) - 20000;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      act = (r < 3) ? tscu_pkg::ACT_CLEAR : (r < 5) ? ACT_UNUSED :
            (r < 62) ? tscu_pkg::ACT_INSERT : tscu_pkg::ACT_LABEL;
      c = $urandom_range(0, 5);
      send_item(act, pick_coord(centers[c][0], spread), pick_coord(centers[c][1], spread),
                pick_coord(centers[c][2], spread), pick_coord(centers[c][3], spread));
    end
    drain();
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_cycles = 400;
    test_random_phase(40);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_lowered_limit();
    test_backpressure();
    for (int p = 0; p < 12; p++) begin
      no_idle = (p == 4 || p == 9);
      test_random_phase(140);
    end
    no_idle = 1'b0;
    test_random_phase(40);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result receiver and checker.
  initial begin
    result_t exp_r;
    int gap;
    wait (rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0 || hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_cycles > 0) begin
          @(posedge clk);
          hold_cycles--;
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with no transaction pending");
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r != {label, live_count, created, merged}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch label %0d/%0d live %0d/%0d created %0d/%0d merged %0d/%0d",
                     exp_r.label, label, exp_r.live, live_count, exp_r.created, created,
                     exp_r.merged, merged);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tscu_pkg.sv
hdl/tscu_div.sv
hdl/threshold_subcluster_clustering_unit.sv
bench/tb.sv
